// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/i2cmrs_pkg.sv -----
// ---------------------------------------------------------------------------
// I2C master register sequencer package
// Types, codes and constants shared by the sequencer core and top level.
// ---------------------------------------------------------------------------
package i2cmrs_pkg;

  // Transmit buffer geometry
  localparam int unsigned BUFFER_DEPTH = 256;
  localparam int unsigned BUF_IDX_W    = $clog2(BUFFER_DEPTH);

  // Reads need at least three bytes for the three-byte-end procedure
  localparam logic [7:0] READ_MIN_COUNT = 8'd3;

  // Direction bit appended to the device address
  localparam logic DIR_WRITE = 1'b0;
  localparam logic DIR_READ  = 1'b1;

  // Stream field widths
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    OP_START_WRITE = 2'd0,
    OP_START_READ  = 2'd1,
    OP_LOAD        = 2'd2,
    OP_EVENT       = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SEND_NONE = 2'd0,
    SEND_ADDR = 2'd1,
    SEND_DATA = 2'd2
  } send_e;

  typedef enum logic [1:0] {
    CTRL_KEEP    = 2'd0,
    CTRL_ENABLE  = 2'd1,
    CTRL_DISABLE = 2'd2
  } ctrl_e;

  // Write uses START..RESTART (RESTART doubles as final byte-finished wait)
  typedef enum logic [2:0] {
    PH_START   = 3'd0,  // expect start sent
    PH_ADDR    = 3'd1,  // expect address sent
    PH_REG     = 3'd2,  // write: tx empty; read: byte finished
    PH_RESTART = 3'd3,  // write: byte finished; read: repeated start sent
    PH_RD_ADDR = 3'd4,  // expect address sent (receiver)
    PH_RD_BYTE = 3'd5,  // expect rx not empty, single bytes
    PH_RD_PAIR = 3'd6,  // expect byte finished, two bytes and stop
    PH_RD_LAST = 3'd7   // expect rx not empty, last byte
  } phase_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] buffer_index;
    logic [7:0] data_byte;
    logic [7:0] second_rx_byte;
    logic       flag_start_sent;
    logic       flag_address_sent;
    logic       flag_tx_empty;
    logic       flag_byte_finished;
    logic       flag_rx_not_empty;
  } item_t;

  typedef struct packed {
    status_e    status;
    send_e      send_action;
    logic [7:0] send_value;
    logic       start_request;
    logic       stop_request;
    ctrl_e      ack_control;
    ctrl_e      buffer_irq_control;
    ctrl_e      event_irq_control;
    logic [1:0] rx_store_count;
    logic [7:0] rx_index;
    logic [7:0] rx_first;
    logic [7:0] rx_second;
  } result_t;

endpackage

// ----- src/i2cmrs_core.sv -----
// ---------------------------------------------------------------------------
// I2C master register sequencer core
// Transaction state, transmit buffer and per-item phase logic.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cmrs_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  i2cmrs_pkg::item_t   item_i,
  output i2cmrs_pkg::result_t result_o
);

  i2cmrs_pkg::phase_e  phase_q, phase_d;
  i2cmrs_pkg::status_e status_q, status_d;
  logic                is_read_q, is_read_d;
  logic [6:0]          target_q, target_d;
  logic [7:0]          register_q, register_d;
  logic [7:0]          total_q, total_d;
  logic [7:0]          pos_q, pos_d;

  // Transmit buffer and its prefetched read word
  logic [7:0] buffer_mem [i2cmrs_pkg::BUFFER_DEPTH];
  logic [7:0] rd_data_q;
  logic       wr_en;
  logic [i2cmrs_pkg::BUF_IDX_W-1:0] wr_addr;
  logic [i2cmrs_pkg::BUF_IDX_W-1:0] rd_addr;

  logic [7:0]          pos_inc;
  i2cmrs_pkg::result_t res;

  assign pos_inc = pos_q + 8'd1;
  assign wr_addr = item_i.buffer_index[i2cmrs_pkg::BUF_IDX_W-1:0];
  assign rd_addr = pos_d[i2cmrs_pkg::BUF_IDX_W-1:0];

  // Disable the acknowledge and both interrupt controls of a failing result
  function automatic i2cmrs_pkg::result_t fail_res(i2cmrs_pkg::result_t r);
    i2cmrs_pkg::result_t f;
    f = r;
    f.ack_control        = i2cmrs_pkg::CTRL_DISABLE;
    f.buffer_irq_control = i2cmrs_pkg::CTRL_DISABLE;
    f.event_irq_control  = i2cmrs_pkg::CTRL_DISABLE;
    return f;
  endfunction

  // Decode one item into next state and its result
  always_comb begin
    phase_d    = phase_q;
    status_d   = status_q;
    is_read_d  = is_read_q;
    target_d   = target_q;
    register_d = register_q;
    total_d    = total_q;
    pos_d      = pos_q;
    wr_en      = 1'b0;
    res        = '0;
    if (accept_i) begin
      unique case (item_i.opcode)
        i2cmrs_pkg::OP_START_WRITE, i2cmrs_pkg::OP_START_READ: begin
          if (status_q == i2cmrs_pkg::ST_OK) begin
            if (item_i.opcode == i2cmrs_pkg::OP_START_READ &&
                item_i.byte_count < i2cmrs_pkg::READ_MIN_COUNT) begin
              status_d = i2cmrs_pkg::ST_ERROR;
            end else begin
              is_read_d  = (item_i.opcode == i2cmrs_pkg::OP_START_READ);
              target_d   = item_i.device_address;
              register_d = item_i.register_address;
              total_d    = item_i.byte_count;
              pos_d      = '0;
              phase_d    = i2cmrs_pkg::PH_START;
              status_d   = i2cmrs_pkg::ST_BUSY;
              res.start_request     = 1'b1;
              res.event_irq_control = i2cmrs_pkg::CTRL_ENABLE;
              if (item_i.opcode == i2cmrs_pkg::OP_START_READ) begin
                res.ack_control = i2cmrs_pkg::CTRL_ENABLE;
              end
            end
          end
        end
        i2cmrs_pkg::OP_LOAD: begin
          wr_en = ({1'b0, item_i.buffer_index} < 9'(i2cmrs_pkg::BUFFER_DEPTH));
        end
        i2cmrs_pkg::OP_EVENT: begin
          if (status_q == i2cmrs_pkg::ST_BUSY) begin
            unique case (phase_q)
              i2cmrs_pkg::PH_START: begin
                if (!item_i.flag_start_sent) begin
                  res = fail_res(res);
                  status_d = i2cmrs_pkg::ST_ERROR;
                  phase_d  = i2cmrs_pkg::PH_START;
                end else begin
                  res.send_action = i2cmrs_pkg::SEND_ADDR;
                  res.send_value  = {target_q, i2cmrs_pkg::DIR_WRITE};
                  phase_d = i2cmrs_pkg::PH_ADDR;
                end
              end
              i2cmrs_pkg::PH_ADDR: begin
                if (!item_i.flag_address_sent) begin
                  res = fail_res(res);
                  status_d = i2cmrs_pkg::ST_ERROR;
                  phase_d  = i2cmrs_pkg::PH_START;
                end else begin
                  if (!is_read_q) begin
                    res.buffer_irq_control = i2cmrs_pkg::CTRL_ENABLE;
                  end
                  res.send_action = i2cmrs_pkg::SEND_DATA;
                  res.send_value  = register_q;
                  phase_d = i2cmrs_pkg::PH_REG;
                end
              end
              i2cmrs_pkg::PH_REG: begin
                if (!is_read_q) begin
                  if (!item_i.flag_tx_empty) begin
                    res = fail_res(res);
                    status_d = i2cmrs_pkg::ST_ERROR;
                    phase_d  = i2cmrs_pkg::PH_START;
                  end else if (pos_q >= total_q) begin
                    res.buffer_irq_control = i2cmrs_pkg::CTRL_DISABLE;
                    phase_d = i2cmrs_pkg::PH_RESTART;
                  end else begin
                    res.send_action = i2cmrs_pkg::SEND_DATA;
                    res.send_value  = rd_data_q;
                    pos_d = pos_inc;
                  end
                end else if (!item_i.flag_byte_finished) begin
                  res = fail_res(res);
                  status_d = i2cmrs_pkg::ST_ERROR;
                  phase_d  = i2cmrs_pkg::PH_START;
                end else begin
                  res.start_request = 1'b1;
                  phase_d = i2cmrs_pkg::PH_RESTART;
                end
              end
              i2cmrs_pkg::PH_RESTART: begin
                if (!is_read_q) begin
                  if (!item_i.flag_byte_finished) begin
                    res = fail_res(res);
                    status_d = i2cmrs_pkg::ST_ERROR;
                    phase_d  = i2cmrs_pkg::PH_START;
                  end else begin
                    res.stop_request       = 1'b1;
                    res.buffer_irq_control = i2cmrs_pkg::CTRL_DISABLE;
                    res.event_irq_control  = i2cmrs_pkg::CTRL_DISABLE;
                    status_d = i2cmrs_pkg::ST_OK;
                    phase_d  = i2cmrs_pkg::PH_START;
                  end
                end else if (!item_i.flag_start_sent) begin
                  res = fail_res(res);
                  status_d = i2cmrs_pkg::ST_ERROR;
                  phase_d  = i2cmrs_pkg::PH_START;
                end else begin
                  res.send_action = i2cmrs_pkg::SEND_ADDR;
                  res.send_value  = {target_q, i2cmrs_pkg::DIR_READ};
                  phase_d = i2cmrs_pkg::PH_RD_ADDR;
                end
              end
              i2cmrs_pkg::PH_RD_ADDR: begin
                if (!is_read_q || !item_i.flag_address_sent) begin
                  res = fail_res(res);
                  status_d = i2cmrs_pkg::ST_ERROR;
                  phase_d  = i2cmrs_pkg::PH_START;
                end else if (total_q == i2cmrs_pkg::READ_MIN_COUNT) begin
                  // Exactly three bytes: go straight to the two-byte finish
                  res.buffer_irq_control = i2cmrs_pkg::CTRL_DISABLE;
                  phase_d = i2cmrs_pkg::PH_RD_PAIR;
                end else begin
                  res.buffer_irq_control = i2cmrs_pkg::CTRL_ENABLE;
                  phase_d = i2cmrs_pkg::PH_RD_BYTE;
                end
              end
              i2cmrs_pkg::PH_RD_BYTE: begin
                if (!is_read_q || !item_i.flag_rx_not_empty) begin
                  res = fail_res(res);
                  status_d = i2cmrs_pkg::ST_ERROR;
                  phase_d  = i2cmrs_pkg::PH_START;
                end else begin
                  res.rx_store_count = 2'd1;
                  res.rx_index       = pos_q;
                  res.rx_first       = item_i.data_byte;
                  pos_d = pos_inc;
                  if (pos_inc == total_q - i2cmrs_pkg::READ_MIN_COUNT) begin
                    res.buffer_irq_control = i2cmrs_pkg::CTRL_DISABLE;
                    phase_d = i2cmrs_pkg::PH_RD_PAIR;
                  end
                end
              end
              i2cmrs_pkg::PH_RD_PAIR: begin
                if (!is_read_q || !item_i.flag_byte_finished) begin
                  res = fail_res(res);
                  status_d = i2cmrs_pkg::ST_ERROR;
                  phase_d  = i2cmrs_pkg::PH_START;
                end else begin
                  res.ack_control        = i2cmrs_pkg::CTRL_DISABLE;
                  res.stop_request       = 1'b1;
                  res.buffer_irq_control = i2cmrs_pkg::CTRL_ENABLE;
                  res.rx_store_count     = 2'd2;
                  res.rx_index           = pos_q;
                  res.rx_first           = item_i.data_byte;
                  res.rx_second          = item_i.second_rx_byte;
                  pos_d   = pos_q + 8'd2;
                  phase_d = i2cmrs_pkg::PH_RD_LAST;
                end
              end
              i2cmrs_pkg::PH_RD_LAST: begin
                if (!is_read_q || !item_i.flag_rx_not_empty) begin
                  res = fail_res(res);
                  status_d = i2cmrs_pkg::ST_ERROR;
                  phase_d  = i2cmrs_pkg::PH_START;
                end else begin
                  res.rx_store_count     = 2'd1;
                  res.rx_index           = pos_q;
                  res.rx_first           = item_i.data_byte;
                  res.buffer_irq_control = i2cmrs_pkg::CTRL_DISABLE;
                  res.event_irq_control  = i2cmrs_pkg::CTRL_DISABLE;
                  status_d = i2cmrs_pkg::ST_OK;
                  phase_d  = i2cmrs_pkg::PH_START;
                end
              end
              default: begin
                res = fail_res(res);
                status_d = i2cmrs_pkg::ST_ERROR;
                phase_d  = i2cmrs_pkg::PH_START;
              end
            endcase
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
    res.status = status_d;
  end

  assign result_o = res;

  // Hold transaction state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= i2cmrs_pkg::PH_START;
      status_q   <= i2cmrs_pkg::ST_OK;
      is_read_q  <= 1'b0;
      target_q   <= '0;
      register_q <= '0;
      total_q    <= '0;
      pos_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      status_q   <= status_d;
      is_read_q  <= is_read_d;
      target_q   <= target_d;
      register_q <= register_d;
      total_q    <= total_d;
      pos_q      <= pos_d;
    end
  end

  // Write the buffer; prefetch the entry at the next byte position,
  // forwarding a load to the same entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buffer_mem[wr_addr] <= item_i.data_byte;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_q <= item_i.data_byte;
    end else begin
      rd_data_q <= buffer_mem[rd_addr];
    end
  end

  `ASSERT_NEXT(a_error_sticky, status_q == i2cmrs_pkg::ST_ERROR,
               status_q == i2cmrs_pkg::ST_ERROR, "error status cleared without reset")
  `ASSERT_CLK(a_idle_phase, (status_q == i2cmrs_pkg::ST_BUSY) || (phase_q == i2cmrs_pkg::PH_START),
              "phase left away from start while not busy")
  `ASSERT_CLK(a_write_phase, is_read_q || (phase_q == i2cmrs_pkg::PH_START) ||
              (phase_q == i2cmrs_pkg::PH_ADDR) || (phase_q == i2cmrs_pkg::PH_REG) ||
              (phase_q == i2cmrs_pkg::PH_RESTART), "write transaction in a read phase")

endmodule

// ----- src/i2c_master_register_sequencer.sv -----
// ---------------------------------------------------------------------------
// I2C master register sequencer
// Stream front end: unpacks items, runs the core, registers each result.
// ---------------------------------------------------------------------------
// One result per item. An item is taken every clock cycle as long as the
// output register is empty or being drained, and its result appears in the
// output register the cycle after acceptance. The transmit buffer is a single
// memory whose entry at the next byte position is prefetched every
// cycle (a load to that entry is forwarded), so data sends never stall.
// The buffer has no reset and no clearing pass; entries must be loaded
// before a write transaction sends them.
`include "assert_macros.svh"

module i2c_master_register_sequencer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [6:0] device_address, [14:7] register_address, [22:15] byte_count,
  // [30:23] buffer_index, [38:31] data_byte, [46:39] second_rx_byte,
  // [47] flag_start_sent, [48] flag_address_sent, [49] flag_tx_empty,
  // [50] flag_byte_finished, [51] flag_rx_not_empty, [55:52] zero
  input  logic [i2cmrs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] opcode
  input  logic [i2cmrs_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] status, [3:2] send_action, [11:4] send_value, [12] start_request,
  // [13] stop_request, [15:14] ack_control, [17:16] buffer_irq_control,
  // [19:18] event_irq_control, [21:20] rx_store_count, [29:22] rx_index,
  // [37:30] rx_first, [45:38] rx_second, [47:46] zero
  output logic [i2cmrs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  i2cmrs_pkg::item_t   item;
  i2cmrs_pkg::result_t result;
  logic                accept;
  logic                out_valid_q;
  logic [i2cmrs_pkg::OUT_DATA_W-1:0] out_data_q;

  // Accept when the output register is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Unpack the input transaction
  always_comb begin
    item.opcode             = i2cmrs_pkg::opcode_e'(s_axis_tuser);
    item.device_address     = s_axis_tdata[6:0];
    item.register_address   = s_axis_tdata[14:7];
    item.byte_count         = s_axis_tdata[22:15];
    item.buffer_index       = s_axis_tdata[30:23];
    item.data_byte          = s_axis_tdata[38:31];
    item.second_rx_byte     = s_axis_tdata[46:39];
    item.flag_start_sent    = s_axis_tdata[47];
    item.flag_address_sent  = s_axis_tdata[48];
    item.flag_tx_empty      = s_axis_tdata[49];
    item.flag_byte_finished = s_axis_tdata[50];
    item.flag_rx_not_empty  = s_axis_tdata[51];
  end

  i2cmrs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .result_o (result)
  );

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Pack the result transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {2'b00, result.rx_second, result.rx_first, result.rx_index,
                     result.rx_store_count, result.event_irq_control,
                     result.buffer_irq_control, result.ack_control,
                     result.stop_request, result.start_request,
                     result.send_value, result.send_action, result.status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `ASSERT_NEXT(a_accept_gives_result, accept, out_valid_q,
               "accepted item produced no result")

endmodule

// ----- tb/i2c_master_register_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C master register sequencer testbench
// Drives start, load and peripheral event transactions into the sequencer.
// An in-bench predictor tracks the transaction phases and forecasts every
// result, which is then compared field by field. Both sides stall at random,
// and the receiver also holds off for a long stretch once. Sticky errors are
// exercised last, since only reset clears them.
// ---------------------------------------------------------------------------
module i2c_master_register_sequencer_tb;
  import i2cmrs_pkg::*;

  localparam int IDLE_PCT    = 29;
  localparam int ITEM_TARGET = 1300;
  localparam int CYCLE_LIMIT = 500000;

  // Peripheral flag that a phase waits for
  typedef enum int {
    NEED_START,
    NEED_ADDR,
    NEED_TXE,
    NEED_BF,
    NEED_RXNE
  } flag_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Predicted sequencer state
  phase_e     exp_phase   = PH_START;
  logic       exp_is_read = 1'b0;
  status_e    exp_status  = ST_OK;
  logic [6:0] exp_device  = '0;
  logic [7:0] exp_reg     = '0;
  logic [7:0] exp_total   = '0;
  logic [7:0] exp_pos     = '0;
  logic [7:0] tx_shadow [BUFFER_DEPTH];
  bit         tx_written [BUFFER_DEPTH];

  result_t pending_results [$];
  int      error_count     = 0;
  int      items_sent      = 0;
  int      cycle_count     = 0;
  int      hold_request    = 0;
  int      hold_left       = 0;
  bit      sender_steady   = 1'b0;
  bit      receiver_steady = 1'b0;

  i2c_master_register_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // End the run if it hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("i2c_master_register_sequencer_tb failed");
      $finish;
    end
  end

  // Drop the abort outputs and park the sequencer in the sticky error
  function automatic void abort_transaction(inout result_t r);
    exp_status = ST_ERROR;
    exp_phase  = PH_START;
    r.ack_control        = CTRL_DISABLE;
    r.buffer_irq_control = CTRL_DISABLE;
    r.event_irq_control  = CTRL_DISABLE;
  endfunction

  // Write direction: address, register byte, data bytes, stop
  function automatic void write_phase_step(input item_t it, inout result_t r);
    case (exp_phase)
      PH_START: begin
        if (!it.flag_start_sent) abort_transaction(r);
        else begin
          r.send_action = SEND_ADDR;
          r.send_value  = {exp_device, DIR_WRITE};
          exp_phase     = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (!it.flag_address_sent) abort_transaction(r);
        else begin
          r.buffer_irq_control = CTRL_ENABLE;
          r.send_action        = SEND_DATA;
          r.send_value         = exp_reg;
          exp_phase            = PH_REG;
        end
      end
      PH_REG: begin
        if (!it.flag_tx_empty) abort_transaction(r);
        else if (exp_pos >= exp_total) begin
          r.buffer_irq_control = CTRL_DISABLE;
          exp_phase            = PH_RESTART;
        end else begin
          r.send_action = SEND_DATA;
          r.send_value  = tx_shadow[exp_pos];
          exp_pos       = exp_pos + 8'd1;
        end
      end
      PH_RESTART: begin
        if (!it.flag_byte_finished) abort_transaction(r);
        else begin
          r.stop_request       = 1'b1;
          r.buffer_irq_control = CTRL_DISABLE;
          r.event_irq_control  = CTRL_DISABLE;
          exp_status           = ST_OK;
          exp_phase            = PH_START;
        end
      end
      default: abort_transaction(r);
    endcase
  endfunction

  // Read direction: register byte, repeated start, three-byte end
  function automatic void read_phase_step(input item_t it, inout result_t r);
    logic [7:0] single_end;
    single_end = exp_total - 8'd3;
    case (exp_phase)
      PH_START: begin
        if (!it.flag_start_sent) abort_transaction(r);
        else begin
          r.send_action = SEND_ADDR;
          r.send_value  = {exp_device, DIR_WRITE};
          exp_phase     = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (!it.flag_address_sent) abort_transaction(r);
        else begin
          r.send_action = SEND_DATA;
          r.send_value  = exp_reg;
          exp_phase     = PH_REG;
        end
      end
      PH_REG: begin
        if (!it.flag_byte_finished) abort_transaction(r);
        else begin
          r.start_request = 1'b1;
          exp_phase       = PH_RESTART;
        end
      end
      PH_RESTART: begin
        if (!it.flag_start_sent) abort_transaction(r);
        else begin
          r.send_action = SEND_ADDR;
          r.send_value  = {exp_device, DIR_READ};
          exp_phase     = PH_RD_ADDR;
        end
      end
      PH_RD_ADDR: begin
        if (!it.flag_address_sent) abort_transaction(r);
        else if (exp_total == READ_MIN_COUNT) begin
          // exactly three bytes: go straight to the pair
          r.buffer_irq_control = CTRL_DISABLE;
          exp_phase            = PH_RD_PAIR;
        end else begin
          r.buffer_irq_control = CTRL_ENABLE;
          exp_phase            = PH_RD_BYTE;
        end
      end
      PH_RD_BYTE: begin
        if (!it.flag_rx_not_empty) abort_transaction(r);
        else begin
          r.rx_store_count = 2'd1;
          r.rx_index       = exp_pos;
          r.rx_first       = it.data_byte;
          exp_pos          = exp_pos + 8'd1;
          if (exp_pos == single_end) begin
            r.buffer_irq_control = CTRL_DISABLE;
            exp_phase            = PH_RD_PAIR;
          end
        end
      end
      PH_RD_PAIR: begin
        if (!it.flag_byte_finished) abort_transaction(r);
        else begin
          r.ack_control        = CTRL_DISABLE;
          r.stop_request       = 1'b1;
          r.buffer_irq_control = CTRL_ENABLE;
          r.rx_store_count     = 2'd2;
          r.rx_index           = exp_pos;
          r.rx_first           = it.data_byte;
          r.rx_second          = it.second_rx_byte;
          exp_pos              = exp_pos + 8'd2;
          exp_phase            = PH_RD_LAST;
        end
      end
      PH_RD_LAST: begin
        if (!it.flag_rx_not_empty) abort_transaction(r);
        else begin
          r.rx_store_count     = 2'd1;
          r.rx_index           = exp_pos;
          r.rx_first           = it.data_byte;
          r.buffer_irq_control = CTRL_DISABLE;
          r.event_irq_control  = CTRL_DISABLE;
          exp_status           = ST_OK;
          exp_phase            = PH_START;
        end
      end
      default: abort_transaction(r);
    endcase
  endfunction

  // Advance the predicted state by one item and return its result
  function automatic result_t next_result(input item_t it);
    result_t r;
    r = '0;
    case (it.opcode)
      OP_START_WRITE, OP_START_READ: begin
        if (exp_status == ST_OK) begin
          if (it.opcode == OP_START_READ && it.byte_count < READ_MIN_COUNT) begin
            exp_status = ST_ERROR;
          end else begin
            exp_is_read = (it.opcode == OP_START_READ);
            exp_device  = it.device_address;
            exp_reg     = it.register_address;
            exp_total   = it.byte_count;
            exp_pos     = '0;
            exp_phase   = PH_START;
            exp_status  = ST_BUSY;
            r.start_request     = 1'b1;
            r.event_irq_control = CTRL_ENABLE;
            if (exp_is_read) r.ack_control = CTRL_ENABLE;
          end
        end
      end
      OP_LOAD: begin
        if (it.buffer_index < BUFFER_DEPTH) begin
          tx_shadow[it.buffer_index]  = it.data_byte;
          tx_written[it.buffer_index] = 1'b1;
        end
      end
      default: begin
        if (exp_status == ST_BUSY) begin
          if (exp_is_read) read_phase_step(it, r);
          else write_phase_step(it, r);
        end
      end
    endcase
    r.status = exp_status;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Check each delivered result against the oldest forecast
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result %h arrived with nothing expected", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, m_axis_tdata[1:0]);
        compare_field("send_action", want.send_action, m_axis_tdata[3:2]);
        compare_field("send_value", want.send_value, m_axis_tdata[11:4]);
        compare_field("start_request", want.start_request, m_axis_tdata[12]);
        compare_field("stop_request", want.stop_request, m_axis_tdata[13]);
        compare_field("ack_control", want.ack_control, m_axis_tdata[15:14]);
        compare_field("buffer_irq_control", want.buffer_irq_control,
                      m_axis_tdata[17:16]);
        compare_field("event_irq_control", want.event_irq_control,
                      m_axis_tdata[19:18]);
        compare_field("rx_store_count", want.rx_store_count, m_axis_tdata[21:20]);
        compare_field("rx_index", want.rx_index, m_axis_tdata[29:22]);
        compare_field("rx_first", want.rx_first, m_axis_tdata[37:30]);
        compare_field("rx_second", want.rx_second, m_axis_tdata[45:38]);
      end
    end
  end

  // Drive the result ready: random stalls, steady stretches, long hold-off
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= receiver_steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic item_t random_item(input opcode_e op);
    item_t it;
    it.opcode             = op;
    it.device_address     = 7'($urandom);
    it.register_address   = 8'($urandom);
    it.byte_count         = 8'($urandom);
    it.buffer_index       = 8'($urandom);
    it.data_byte          = 8'($urandom);
    it.second_rx_byte     = 8'($urandom);
    it.flag_start_sent    = 1'($urandom);
    it.flag_address_sent  = 1'($urandom);
    it.flag_tx_empty      = 1'($urandom);
    it.flag_byte_finished = 1'($urandom);
    it.flag_rx_not_empty  = 1'($urandom);
    return it;
  endfunction

  // Event with the awaited flag forced, all other content random
  function automatic item_t event_item(input flag_e need, input bit present);
    item_t it;
    it = random_item(OP_EVENT);
    case (need)
      NEED_START: it.flag_start_sent    = present;
      NEED_ADDR:  it.flag_address_sent  = present;
      NEED_TXE:   it.flag_tx_empty      = present;
      NEED_BF:    it.flag_byte_finished = present;
      default:    it.flag_rx_not_empty  = present;
    endcase
    return it;
  endfunction

  // Offer one item, hold it until accepted and record its forecast
  task automatic send_item(input item_t it);
    while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.opcode;
    s_axis_tdata  <= {4'b0, it.flag_rx_not_empty, it.flag_byte_finished,
                      it.flag_tx_empty, it.flag_address_sent, it.flag_start_sent,
                      it.second_rx_byte, it.data_byte, it.buffer_index,
                      it.byte_count, it.register_address, it.device_address};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (it.opcode != OP_EVENT || exp_status == ST_BUSY) items_sent++;
    pending_results.push_back(next_result(it));
    @(negedge clk_i);
  endtask

  // Loads and refused starts slipped in between events of a busy transaction
  task automatic busy_noise(input int noise_pct);
    item_t it;
    while ($urandom_range(99) < noise_pct) begin
      if ($urandom_range(1)) it = random_item(OP_LOAD);
      else it = random_item($urandom_range(1) ? OP_START_READ : OP_START_WRITE);
      send_item(it);
    end
  endtask

  // One register transaction; break_at names an event sent without its flag
  task automatic run_transaction(input opcode_e op, input logic [6:0] device,
                                 input logic [7:0] regad, input logic [7:0] count,
                                 input int noise_pct, input bit refuse_probe,
                                 input int break_at);
    flag_e steps [$];
    item_t it;
    int    i;
    if (op == OP_START_WRITE) begin
      // make sure every byte that will be sent has been loaded
      for (i = 0; i < count; i++) begin
        if (!tx_written[i]) begin
          it = random_item(OP_LOAD);
          it.buffer_index = 8'(i);
          send_item(it);
        end
      end
      steps = '{NEED_START, NEED_ADDR};
      for (i = 0; i <= count; i++) steps.push_back(NEED_TXE);
      steps.push_back(NEED_BF);
    end else begin
      steps = '{NEED_START, NEED_ADDR, NEED_BF, NEED_START, NEED_ADDR};
      for (i = 3; i < count; i++) steps.push_back(NEED_RXNE);
      steps.push_back(NEED_BF);
      steps.push_back(NEED_RXNE);
    end
    it = random_item(op);
    it.device_address   = device;
    it.register_address = regad;
    it.byte_count       = count;
    send_item(it);
    if (refuse_probe) begin
      // a short read offered while busy is refused without an error
      it = random_item(OP_START_READ);
      it.byte_count = 8'd0;
      send_item(it);
    end
    foreach (steps[k]) begin
      busy_noise(noise_pct);
      send_item(event_item(steps[k], k != break_at));
      if (k == break_at) return;
    end
  endtask

  function automatic logic [7:0] pick_count(input int floor_count);
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return 8'($urandom_range(floor_count + 6, floor_count));
    if (roll < 96) return 8'($urandom_range(60, floor_count));
    return 8'($urandom_range(255, 200));
  endfunction

  // Extreme addresses and data on a write, plus an event while idle
  task automatic test_write_extremes;
    item_t it;
    send_item(event_item(NEED_START, 1'b1));
    it = random_item(OP_LOAD);
    it.buffer_index = 8'd0;
    it.data_byte    = 8'hFF;
    send_item(it);
    run_transaction(OP_START_WRITE, 7'h7F, 8'hFF, 8'd1, 0, 1'b0, -1);
  endtask

  // Read of exactly three bytes and the shortest read with a single byte
  task automatic test_read_short_paths;
    run_transaction(OP_START_READ, 7'h00, 8'h00, 8'd3, 0, 1'b0, -1);
    run_transaction(OP_START_READ, 7'h55, 8'hAA, 8'd4, 0, 1'b1, -1);
  endtask

  // Hold the receiver off while the sender keeps offering items
  task automatic test_back_pressure;
    sender_steady = 1'b1;
    hold_request  = 150;
    run_transaction(OP_START_READ, 7'($urandom), 8'($urandom), 8'd12, 0, 1'b0, -1);
    run_transaction(OP_START_WRITE, 7'($urandom), 8'($urandom), 8'd5, 0, 1'b0, -1);
    sender_steady = 1'b0;
  endtask

  // Well-formed transactions with random content and noise in between
  task automatic test_random_traffic;
    item_t it;
    while (items_sent < ITEM_TARGET) begin
      sender_steady   = (items_sent >= 500 && items_sent < 700);
      receiver_steady = sender_steady;
      // idle noise: ignored events and loads
      repeat ($urandom_range(2)) begin
        it = random_item($urandom_range(1) ? OP_EVENT : OP_LOAD);
        send_item(it);
      end
      if ($urandom_range(1))
        run_transaction(OP_START_WRITE, 7'($urandom), 8'($urandom), pick_count(0),
                        12, 1'b0, -1);
      else
        run_transaction(OP_START_READ, 7'($urandom), 8'($urandom), pick_count(3),
                        12, 1'b0, -1);
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
  endtask

  // Enter the sticky error, then show that only loads still take effect
  task automatic test_sticky_error;
    item_t      it;
    logic [7:0] count;
    if ($urandom_range(1)) begin
      it = random_item(OP_START_READ);
      it.byte_count = 8'($urandom_range(2));
      send_item(it);
    end else begin
      count = pick_count(3);
      run_transaction($urandom_range(1) ? OP_START_READ : OP_START_WRITE,
                      7'($urandom), 8'($urandom), count, 0, 1'b0,
                      $urandom_range(count + 3));
    end
    it = random_item(OP_START_WRITE);
    send_item(it);
    it = random_item(OP_START_READ);
    it.byte_count = 8'd5;
    send_item(it);
    it = random_item(OP_EVENT);
    {it.flag_start_sent, it.flag_address_sent, it.flag_tx_empty,
     it.flag_byte_finished, it.flag_rx_not_empty} = 5'b11111;
    send_item(it);
    send_item(random_item(OP_LOAD));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_write_extremes();
    test_read_short_paths();
    test_back_pressure();
    test_random_traffic();
    test_sticky_error();

    // Drain the remaining results, then report the outcome
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (error_count == 0) $display("i2c_master_register_sequencer_tb passed");
    else $display("i2c_master_register_sequencer_tb failed");
    $finish;
  end

endmodule
